@@ rtl/jpeg_exif_carver_core_defines.svh @@
// assertion macros for the exif jpeg carver
`ifndef JPEG_EXIF_CARVER_CORE_DEFINES_SVH
`define JPEG_EXIF_CARVER_CORE_DEFINES_SVH

// condition in the same cycle implies consequence
`define JEC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the following cycle
`define JEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/jec_pkg.sv @@
package jec_pkg;

    // position counter width and reported position width
    localparam int POS_BITS = 40;
    localparam int OUT_W    = 40;
    localparam int LEN_W    = 24;
    localparam int BYTE_W   = 8;
    localparam int HIST_D   = 9;

    // apb register map
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam logic REG_MAX_LEN = 1'b0;
    localparam logic REG_MIN_LEN = 1'b1;

    // register reset values
    localparam logic [LEN_W-1:0] MAX_LEN_RST = LEN_W'(5000000);
    localparam logic [LEN_W-1:0] MIN_LEN_RST = LEN_W'(65536);

    // event kinds
    localparam logic EVT_FOUND   = 1'b0;
    localparam logic EVT_ABANDON = 1'b1;

    // marker bytes
    localparam logic [BYTE_W-1:0] MK_FF = 8'hff;
    localparam logic [BYTE_W-1:0] MK_D8 = 8'hd8;
    localparam logic [BYTE_W-1:0] MK_D9 = 8'hd9;
    localparam logic [BYTE_W-1:0] CH_E  = 8'h45;
    localparam logic [BYTE_W-1:0] CH_X  = 8'h78;
    localparam logic [BYTE_W-1:0] CH_I  = 8'h69;
    localparam logic [BYTE_W-1:0] CH_F  = 8'h66;

    // start lies this many bytes before the closing 'f'
    localparam logic [POS_BITS-1:0] START_BACK = POS_BITS'(9);

    typedef logic [POS_BITS-1:0] t_pos;
    typedef logic [BYTE_W-1:0]   t_byte;
    typedef logic [LEN_W-1:0]    t_len;

    // one result item
    typedef struct packed {
        logic             event_kind;
        logic [OUT_W-1:0] image_start;
        logic [OUT_W-1:0] image_end;
    } t_evt;

endpackage

@@ rtl/jec_ifs.sv @@
// byte stream channel
interface jec_in_if;
    logic                     valid;
    logic                     ready;
    logic [jec_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

// carving event channel
interface jec_out_if;
    logic                      valid;
    logic                      ready;
    logic                      event_kind;
    logic [jec_pkg::OUT_W-1:0] image_start;
    logic [jec_pkg::OUT_W-1:0] image_end;

    modport source (output valid, output event_kind, output image_start,
                    output image_end, input ready);
    modport sink (input valid, input event_kind, input image_start,
                  input image_end, output ready);
endinterface

@@ rtl/jpeg_exif_carver_core.sv @@
// Exif JPEG carver: scans a byte stream one byte per transfer and reports each
// embedded image (FF D8, four bytes, then "Exif") as a start/end position pair
// when FF D9 closes it at least min_image_len bytes past the start, or as an
// abandon event once it runs past max_image_len. A byte is taken every clock
// cycle while the skid entry is empty; its event, if any, is registered into
// the output register or skid entry. Each byte's state update is a history
// shift, a position count and one 40-bit length subtract with two compares.
// An output register plus one skid entry hold events while the sink stalls;
// input ready drops only when both are full. Positions saturate at the top
// of the counter. Registers: max_image_len at address 0, min_image_len at 4,
// 24 bits each in the low bits of the word; write only while the stream is idle.
`include "jpeg_exif_carver_core_defines.svh"

module jpeg_exif_carver_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    jec_in_if.sink                      i_in,
    jec_out_if.source                   o_evt,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [jec_pkg::ADDR_W-1:0]  paddr,
    input  logic [jec_pkg::DATA_W-1:0]  pwdata,
    output logic [jec_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    // scan state
    jec_pkg::t_byte r_hist [jec_pkg::HIST_D];
    jec_pkg::t_pos  r_pos, n_pos;
    jec_pkg::t_pos  r_start, n_start;
    logic           r_inside, n_inside;

    // configuration
    jec_pkg::t_len  r_max_len;
    jec_pkg::t_len  r_min_len;

    // output register and skid entry
    jec_pkg::t_evt  r_out, n_out;
    logic           r_out_v, n_out_v;
    jec_pkg::t_evt  r_skd, n_skd;
    logic           r_skd_v, n_skd_v;

    logic           in_xfer;
    logic           out_xfer;
    logic           cfg_wr;
    jec_pkg::t_byte cur;
    jec_pkg::t_pos  img_len;
    logic           too_long;
    logic           long_enough;
    logic           abandon;
    logic           still_in;
    logic           found;
    logic           kept_in;
    logic           start_hit;
    logic           push;
    jec_pkg::t_evt  evt;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = o_evt.valid && o_evt.ready;
    assign cur      = i_in.data_byte;

    // register read
    always_comb begin
        unique case (paddr[2])
            jec_pkg::REG_MAX_LEN: prdata = jec_pkg::DATA_W'(r_max_len);
            jec_pkg::REG_MIN_LEN: prdata = jec_pkg::DATA_W'(r_min_len);
            default:              prdata = '0;
        endcase
    end

    // length checks against the current image start
    assign img_len     = r_pos - r_start;
    assign too_long    = img_len > jec_pkg::t_pos'(r_max_len);
    assign long_enough = img_len >= jec_pkg::t_pos'(r_min_len);

    // abandon first, then end marker, then start pattern
    assign abandon   = r_inside && too_long;
    assign still_in  = r_inside && !abandon;
    assign found     = still_in && (r_hist[0] == jec_pkg::MK_FF)
                       && (cur == jec_pkg::MK_D9) && long_enough;
    assign kept_in   = still_in && !found;
    assign start_hit = !kept_in
                       && (r_hist[8] == jec_pkg::MK_FF) && (r_hist[7] == jec_pkg::MK_D8)
                       && (r_hist[2] == jec_pkg::CH_E) && (r_hist[1] == jec_pkg::CH_X)
                       && (r_hist[0] == jec_pkg::CH_I) && (cur == jec_pkg::CH_F);
    assign push      = in_xfer && (abandon || found);

    // event payload
    always_comb begin
        evt.event_kind  = abandon ? jec_pkg::EVT_ABANDON : jec_pkg::EVT_FOUND;
        evt.image_start = jec_pkg::OUT_W'(r_start);
        evt.image_end   = jec_pkg::OUT_W'(r_pos);
    end

    // next scan state
    always_comb begin
        n_inside = kept_in || start_hit;
        n_start  = r_start;
        if (start_hit) begin
            n_start = (r_pos >= jec_pkg::START_BACK) ? r_pos - jec_pkg::START_BACK : '0;
        end
        n_pos = (&r_pos) ? r_pos : r_pos + jec_pkg::t_pos'(1);
    end

    // scan state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < jec_pkg::HIST_D; i++) begin
                r_hist[i] <= '0;
            end
            r_pos    <= '0;
            r_start  <= '0;
            r_inside <= 1'b0;
        end else if (in_xfer) begin
            for (int i = jec_pkg::HIST_D - 1; i > 0; i--) begin
                r_hist[i] <= r_hist[i-1];
            end
            r_hist[0] <= cur;
            r_pos     <= n_pos;
            r_start   <= n_start;
            r_inside  <= n_inside;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= jec_pkg::MAX_LEN_RST;
            r_min_len <= jec_pkg::MIN_LEN_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                jec_pkg::REG_MAX_LEN: r_max_len <= pwdata[jec_pkg::LEN_W-1:0];
                jec_pkg::REG_MIN_LEN: r_min_len <= pwdata[jec_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // output register and skid steering
    always_comb begin
        n_out   = r_out;
        n_out_v = r_out_v;
        n_skd   = r_skd;
        n_skd_v = r_skd_v;
        if (r_out_v && !out_xfer) begin
            if (push) begin
                n_skd   = evt;
                n_skd_v = 1'b1;
            end
        end else if (r_skd_v) begin
            n_out   = r_skd;
            n_out_v = 1'b1;
            n_skd_v = 1'b0;
        end else begin
            n_out   = evt;
            n_out_v = push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skd_v <= 1'b0;
        end else begin
            r_out_v <= n_out_v;
            r_skd_v <= n_skd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_skd <= n_skd;
    end

    // channel outputs
    assign i_in.ready        = !r_skd_v;
    assign o_evt.valid       = r_out_v;
    assign o_evt.event_kind  = r_out.event_kind;
    assign o_evt.image_start = r_out.image_start;
    assign o_evt.image_end   = r_out.image_end;

    // checks
    `JEC_ASSERT_NOW(a_skid_behind_out, r_skd_v, r_out_v, "skid entry held without output event")
    `JEC_ASSERT_NOW(a_start_not_past_pos, r_inside, r_start <= r_pos, "image start beyond position")
    `JEC_ASSERT_NEXT(a_pos_steps, in_xfer, (r_pos == $past(r_pos) + jec_pkg::t_pos'(1)) || (&r_pos), "position did not advance by one")

endmodule
